@@ rtl/asod_pkg.sv @@
// ----------------------------------------------------------------------------
// asod_pkg: shared types and constants for the still/orientation detector
// Datapath command/status structs, opcodes and fixed-point constants.
// ----------------------------------------------------------------------------
package asod_pkg;

  localparam int unsigned TimeW    = 40;
  localparam int unsigned AxisN    = 3;
  localparam int unsigned HoldoffUs = 200000;
  localparam int unsigned GravLsb  = 10042;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  // item opcodes
  localparam logic [1:0] OpStart  = 2'd0;
  localparam logic [1:0] OpSample = 2'd1;

  // register indexes
  localparam logic [2:0] RegLenient  = 3'd0;
  localparam logic [2:0] RegThr      = 3'd1;
  localparam logic [2:0] RegTimeNorm = 3'd2;
  localparam logic [2:0] RegTimeLen  = 3'd3;
  localparam logic [2:0] RegTimeout  = 3'd4;
  localparam logic [2:0] RegErrLim   = 3'd5;
  localparam logic [2:0] RegEmaW     = 3'd6;
  localparam logic [2:0] RegGravThr  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_AXIS,
    ST_DECIDE,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       load;    // capture the input word
    logic       prep;    // compute weight, thresholds
    logic       axis;    // process one axis
    logic [1:0] axis_idx;
    logic       decide;  // finish the item, produce a result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fast;  // item needs no sample processing
  } dp_sts_t;

endpackage

@@ rtl/asod_datapath.sv @@
// ----------------------------------------------------------------------------
// asod_datapath: detector state, per-axis arithmetic and classification
// One axis is handled per cycle; results land in the output register.
// ----------------------------------------------------------------------------
module asod_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  asod_pkg::dp_cmd_t          cmd_i,
  output asod_pkg::dp_sts_t          sts_o,
  input  logic [1:0]                 opcode_i,
  input  logic [asod_pkg::TimeW-1:0] time_us_i,
  input  logic signed [15:0]         accel_x_i,
  input  logic signed [15:0]         accel_y_i,
  input  logic signed [15:0]         accel_z_i,
  input  logic                       lenient_i,
  input  logic [23:0]                thr_i,
  input  logic [23:0]                time_norm_i,
  input  logic [23:0]                time_len_i,
  input  logic [27:0]                timeout_i,
  input  logic [15:0]                err_lim_i,
  input  logic [15:0]                ema_w_i,
  input  logic [14:0]                grav_thr_i,
  output logic                       done_res_o,
  output logic [2:0]                 orientation_o,
  output logic                       active_o
);

  localparam int unsigned TW = asod_pkg::TimeW;

  // captured word
  logic [1:0]         op_q;
  logic [TW-1:0]      t_q;
  logic signed [15:0] acc_q [asod_pkg::AxisN];

  // detector state
  logic               run_q;
  logic signed [31:0] avg_q [asod_pkg::AxisN];
  logic [31:0]        disp_q [asod_pkg::AxisN];
  logic [TW-1:0]      prev_q, since_q, dl_q, hold_q;
  logic               seen_q;
  logic [15:0]        late_q;

  // per-item working values
  logic [16:0]        w_q;
  logic [27:0]        thr2_q;
  logic               all_low_q, any_high_q;

  // output
  logic               done_q, act_q;
  logic [2:0]         ori_q;

  // ---- weight: dt * ema_w, saturated at 1.0
  logic [TW-1:0] dt;
  logic [55:0]   wprod;
  logic [39:0]   wsh;
  logic [16:0]   w_d;
  assign dt    = (t_q >= prev_q) ? (t_q - prev_q) : '0;
  // dt above 2^33 saturates for any nonzero weight; the product is 56 bits wide
  assign wprod = {16'd0, dt} * {40'd0, ema_w_i};
  assign wsh   = wprod[55:16];
  assign w_d   = (wsh > 40'd65536) ? 17'd65536 : wsh[16:0];

  // ---- per-axis step
  logic [1:0]         ai;
  logic signed [24:0] s_ext;
  logic signed [33:0] dlt;
  logic [33:0]        adl;
  logic [67:0]        sq_full;
  logic [51:0]        sq;
  logic [48:0]        dprod;
  logic [32:0]        dec;
  logic signed [51:0] wd;
  logic signed [35:0] wdf;
  logic [30:0]        clip;
  logic [51:0]        sqc;
  logic [32:0]        dnew;
  logic [29:0]        thr4;
  assign ai    = cmd_i.axis_idx;
  // sample in Q8, sign carried into the wider difference
  assign s_ext = 25'($signed({acc_q[ai], 8'd0}));
  assign dlt   = 34'(s_ext) - 34'(avg_q[ai]);
  assign adl   = dlt[33] ? (-dlt) : dlt;
  assign sq_full = {34'd0, adl} * {34'd0, adl};
  assign sq    = sq_full[67:16];
  assign dprod = {17'd0, disp_q[ai]} * {32'd0, 17'd65536 - w_q};
  assign dec   = {1'b0, dprod[47:16]};
  assign wd    = 52'(dlt) * $signed({35'd0, w_q});
  assign wdf   = wd[51:16];
  assign clip  = {thr2_q, 3'b000};
  assign sqc   = (sq > 52'(clip)) ? 52'(clip) : sq;
  assign dnew  = (sqc > 52'(dec)) ? sqc[32:0] : dec;
  assign thr4  = {thr2_q, 2'b00};

  // ---- finish logic
  logic [TW:0]   need_sum;
  logic [23:0]   need;
  logic          finish_still;
  logic [TW:0]   dl_sum, hold_sum;
  assign need     = lenient_i ? time_len_i : time_norm_i;
  assign need_sum = {1'b0, since_q} + (TW+1)'(need);
  assign finish_still = all_low_q && seen_q && ({1'b0, t_q} > need_sum);
  assign dl_sum   = {1'b0, t_q} + (TW+1)'(timeout_i);
  assign hold_sum = {1'b0, t_q} + (TW+1)'(asod_pkg::HoldoffUs);

  logic [TW-1:0] dl_sat, hold_sat;
  assign dl_sat   = dl_sum[TW] ? asod_pkg::TimeMax : dl_sum[TW-1:0];
  assign hold_sat = hold_sum[TW] ? asod_pkg::TimeMax : hold_sum[TW-1:0];

  // ---- classification
  function automatic logic near(input logic signed [31:0] v, input logic signed [31:0] tg,
                                input logic [22:0] th);
    logic signed [32:0] d;
    logic [32:0]        a;
    d = 33'(v) - 33'(tg);
    a = d[32] ? (-d) : d;
    return a < 33'(th);
  endfunction

  logic [22:0]        tq8;
  logic signed [31:0] g, ng;
  logic               xp, xn, x0, yp, yn, y0, zp, zn, z0;
  logic [2:0]         cls;
  assign tq8 = {grav_thr_i, 8'd0};
  assign g   = 32'(asod_pkg::GravLsb * 256);
  assign ng  = -g;
  assign xp = near(avg_q[0], g, tq8);
  assign xn = near(avg_q[0], ng, tq8);
  assign x0 = near(avg_q[0], '0, tq8);
  assign yp = near(avg_q[1], g, tq8);
  assign yn = near(avg_q[1], ng, tq8);
  assign y0 = near(avg_q[1], '0, tq8);
  assign zp = near(avg_q[2], g, tq8);
  assign zn = near(avg_q[2], ng, tq8);
  assign z0 = near(avg_q[2], '0, tq8);
  always_comb begin
    if (xp && y0 && z0)      cls = 3'd1;
    else if (xn && y0 && z0) cls = 3'd2;
    else if (x0 && yp && z0) cls = 3'd3;
    else if (x0 && yn && z0) cls = 3'd4;
    else if (x0 && y0 && zp) cls = 3'd5;
    else if (x0 && y0 && zn) cls = 3'd6;
    else                     cls = 3'd0;
  end

  // item skips the sample steps: start, idle, holdoff, or not a sample
  assign sts_o.fast = (op_q != asod_pkg::OpSample) || !run_q || (t_q < hold_q);

  // payload capture and per-item working values
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      t_q    <= time_us_i;
      acc_q[0] <= accel_x_i;
      acc_q[1] <= accel_y_i;
      acc_q[2] <= accel_z_i;
    end
    if (cmd_i.prep) begin
      w_q    <= w_d;
      thr2_q <= lenient_i ? (28'(thr_i) * 28'd9) : 28'(thr_i);
      all_low_q  <= 1'b1;
      any_high_q <= 1'b0;
    end
    if (cmd_i.axis) begin
      if (!(dnew < 33'(thr2_q))) all_low_q <= 1'b0;
      if (dnew > 33'(thr4))      any_high_q <= 1'b1;
    end
  end

  // detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      for (int i = 0; i < asod_pkg::AxisN; i++) begin
        avg_q[i]  <= '0;
        disp_q[i] <= '0;
      end
      prev_q  <= '0;
      since_q <= '0;
      dl_q    <= '0;
      hold_q  <= '0;
      seen_q  <= 1'b0;
      late_q  <= '0;
      done_q  <= 1'b0;
      ori_q   <= '0;
      act_q   <= 1'b0;
    end else begin
      if (cmd_i.prep && !sts_o.fast) prev_q <= t_q;
      if (cmd_i.axis) begin
        avg_q[ai]  <= avg_q[ai] + wdf[31:0];
        disp_q[ai] <= dnew[31:0];
      end
      if (cmd_i.decide) begin
        if (op_q == asod_pkg::OpStart) begin
          done_q  <= 1'b0;
          ori_q   <= '0;
          run_q <= 1'b1;
          for (int i = 0; i < asod_pkg::AxisN; i++) begin
            avg_q[i]  <= '0;
            disp_q[i] <= '0;
          end
          prev_q  <= t_q;
          since_q <= '0;
          seen_q  <= 1'b0;
          dl_q    <= dl_sat;
          late_q  <= '0;
          hold_q  <= '0;
          act_q   <= 1'b1;
        end else if (run_q && t_q >= hold_q) begin
          if (!sts_o.fast && finish_still) begin
            done_q <= 1'b1;
            ori_q  <= cls;
            run_q  <= 1'b0;
            act_q  <= 1'b0;
          end else begin
            logic [15:0]   lc;
            logic [TW-1:0] dl_v;
            lc = late_q;
            dl_v = dl_q;
            if (!sts_o.fast) begin
              if (all_low_q) begin
                if (!seen_q) begin
                  seen_q  <= 1'b1;
                  since_q <= t_q;
                  dl_v    = dl_sat;
                end
              end else if (any_high_q && seen_q) begin
                hold_q <= hold_sat;
                seen_q <= 1'b0;
              end
            end
            dl_q <= dl_v;
            // late test sees the deadline as just moved by still onset;
            // prev_q already updated at prep for samples
            if (prev_q > dl_v && lc != 16'hFFFF) lc = lc + 16'd1;
            late_q <= lc;
            ori_q  <= '0;
            if (lc > err_lim_i) begin
              done_q <= 1'b1;
              run_q  <= 1'b0;
              act_q  <= 1'b0;
            end else begin
              done_q <= 1'b0;
              act_q  <= 1'b1;
            end
          end
        end else begin
          done_q <= 1'b0;
          ori_q  <= '0;
          act_q  <= run_q;
        end
      end
    end
  end

  assign done_res_o    = done_q;
  assign orientation_o = ori_q;
  assign active_o      = act_q;

  // ---- checks
  a_ori_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_q |-> ori_q == 3'd0) else $error("orientation without done");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !act_q) else $error("done while still active");
  a_run_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.decide) |-> act_q == run_q) else $error("active mismatch");

endmodule

@@ rtl/asod_ctrl.sv @@
// ----------------------------------------------------------------------------
// asod_ctrl: sequencer for one word at a time
// Load, prepare, three axis steps, decide, hold result until taken.
// ----------------------------------------------------------------------------
module asod_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output asod_pkg::dp_cmd_t cmd_o,
  input  asod_pkg::dp_sts_t sts_i
);

  asod_pkg::state_e st_q, st_d;
  logic [1:0]       ax_q, ax_d;
  logic             ov_q, ov_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= asod_pkg::ST_IDLE;
      ax_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ax_q <= ax_d;
      ov_q <= ov_d;
    end
  end

  // next state and commands
  always_comb begin
    st_d  = st_q;
    ax_d  = ax_q;
    ov_d  = ov_q;
    cmd_o = '0;
    cmd_o.axis_idx = ax_q;
    in_stall_o = 1'b1;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (st_q)
      asod_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d = asod_pkg::ST_PREP;
        end
      end
      asod_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        ax_d = '0;
        st_d = sts_i.fast ? asod_pkg::ST_DECIDE : asod_pkg::ST_AXIS;
      end
      asod_pkg::ST_AXIS: begin
        cmd_o.axis = 1'b1;
        ax_d = ax_q + 2'd1;
        if (ax_q == 2'd2) st_d = asod_pkg::ST_DECIDE;
      end
      asod_pkg::ST_DECIDE: begin
        // wait until the output register is free
        if (!ov_d) begin
          cmd_o.decide = 1'b1;
          ov_d = 1'b1;
          st_d = asod_pkg::ST_IDLE;
        end
      end
      default: st_d = asod_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.prep, cmd_o.axis, cmd_o.decide}))
    else $error("overlapping commands");
  a_dec_ov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide |=> ov_q) else $error("result lost");
  a_ax_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == asod_pkg::ST_AXIS |-> ax_q != 2'd3) else $error("axis overrun");

endmodule

@@ rtl/accel_still_orientation_detector_unit.sv @@
// Start, tick, spare, idle and holdoff words skip the axis steps; other samples run every one.
// One word is in work at a time: the controller steps one axis per cycle through
// the shared multipliers, and a word waits in decide while the output is held.
// Results wait in an output register; the next word is taken meanwhile.
// Reset (rst_ni low, async) clears detector state and loads register defaults.
// ----------------------------------------------------------------------------
// accel_still_orientation_detector_unit: still detect and orientation
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module accel_still_orientation_detector_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   opcode_i,
  input  logic [39:0]  time_us_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         done_res_o,
  output logic [2:0]   orientation_o,
  output logic         active_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [27:0]  cfg_data_i
);

  logic        len_q;
  logic [23:0] thr_q, tn_q, tl_q;
  logic [27:0] to_q;
  logic [15:0] el_q, ew_q;
  logic [14:0] gt_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 1'b0;
      thr_q <= 24'd65536;
      tn_q  <= 24'd1300000;
      tl_q  <= 24'd500000;
      to_q  <= 28'd10000000;
      el_q  <= 16'd1000;
      ew_q  <= 16'd8590;
      gt_q  <= 15'd5120;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asod_pkg::RegLenient:  len_q <= cfg_data_i[0];
        asod_pkg::RegThr:      thr_q <= cfg_data_i[23:0];
        asod_pkg::RegTimeNorm: tn_q  <= cfg_data_i[23:0];
        asod_pkg::RegTimeLen:  tl_q  <= cfg_data_i[23:0];
        asod_pkg::RegTimeout:  to_q  <= cfg_data_i;
        asod_pkg::RegErrLim:   el_q  <= cfg_data_i[15:0];
        asod_pkg::RegEmaW:     ew_q  <= cfg_data_i[15:0];
        asod_pkg::RegGravThr:  gt_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  asod_pkg::dp_cmd_t cmd;
  asod_pkg::dp_sts_t sts;

  asod_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  asod_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts),
    .opcode_i, .time_us_i, .accel_x_i, .accel_y_i, .accel_z_i,
    .lenient_i(len_q), .thr_i(thr_q), .time_norm_i(tn_q), .time_len_i(tl_q),
    .timeout_i(to_q), .err_lim_i(el_q), .ema_w_i(ew_q), .grav_thr_i(gt_q),
    .done_res_o, .orientation_o, .active_o
  );

endmodule

@@ bench/accel_still_orientation_detector_unit_check.sv @@
// ----------------------------------------------------------------------------
// accel_still_orientation_detector_unit_check: result checker
// Watches the input, output and configuration ports of the still/orientation
// detector, predicts every result word from its own copy of the detector
// state and compares each accepted result, field by field, in order.
// ----------------------------------------------------------------------------
module accel_still_orientation_detector_unit_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         opcode_i,
  input  logic [39:0]        time_us_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               done_res_i,
  input  logic [2:0]         orientation_i,
  input  logic               active_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [27:0]        cfg_data_i,
  output int                 fail_cnt_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 finished_o
);

  typedef struct packed {
    logic       done;
    logic [2:0] orient;
    logic       active;
  } status_t;

  // live copy of the register file
  bit              lenient;
  longint unsigned thr_sq, t_norm, t_len, tmo, err_lim, ema_w, grav_thr;

  // detector state
  bit              running, still_seen;
  int              avg [asod_pkg::AxisN];
  int unsigned     disp [asod_pkg::AxisN];
  longint unsigned prev_t, still_t0, deadline, hold_until;
  int unsigned     late_cnt;

  status_t         status_q [$];

  function automatic longint unsigned time_sat(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > asod_pkg::TimeMax) ? longint'(asod_pkg::TimeMax) : s;
  endfunction

  function automatic bit is_near(longint v, longint target, longint thr);
    longint d;
    d = v - target;
    if (d < 0) d = -d;
    return d < thr;
  endfunction

  // six-side classification of the averaged vector, first match wins
  function automatic logic [2:0] orient_of();
    longint t, g, x, y, z;
    t = longint'(grav_thr) * 256;
    g = longint'(asod_pkg::GravLsb) * 256;
    x = avg[0]; y = avg[1]; z = avg[2];
    if (is_near(x, g, t)  && is_near(y, 0, t)  && is_near(z, 0, t))  return 3'd1;
    if (is_near(x, -g, t) && is_near(y, 0, t)  && is_near(z, 0, t))  return 3'd2;
    if (is_near(x, 0, t)  && is_near(y, g, t)  && is_near(z, 0, t))  return 3'd3;
    if (is_near(x, 0, t)  && is_near(y, -g, t) && is_near(z, 0, t))  return 3'd4;
    if (is_near(x, 0, t)  && is_near(y, 0, t)  && is_near(z, g, t))  return 3'd5;
    if (is_near(x, 0, t)  && is_near(y, 0, t)  && is_near(z, -g, t)) return 3'd6;
    return 3'd0;
  endfunction

  // EMA and dispersion update; returns 1 once the still time has run out
  function automatic bit sample_update(longint unsigned t, longint s_in [asod_pkg::AxisN]);
    longint unsigned thr2, clip, dt, w, ad, sq, dd, need;
    longint          s, d;
    bit              all_low, any_high;
    thr2 = thr_sq * (lenient ? 9 : 1);
    clip = thr2 * 8;
    dt = (t >= prev_t) ? t - prev_t : 0;
    w = (dt * ema_w) >> 16;
    if (w > 65536) w = 65536;
    all_low = 1;
    any_high = 0;
    prev_t = t;
    for (int i = 0; i < asod_pkg::AxisN; i++) begin
      s = s_in[i] * 256;
      d = s - longint'(avg[i]);
      ad = (d < 0) ? -d : d;
      sq = (ad * ad) >> 16;
      dd = (longint'(disp[i]) * (65536 - w)) >> 16;
      avg[i] = int'(longint'(avg[i]) + ((d * longint'(w)) >>> 16));
      if (sq > clip) sq = clip;
      if (sq > dd) dd = sq;
      disp[i] = int'(dd);
      if (!(dd < thr2)) all_low = 0;
      if (dd > thr2 * 4) any_high = 1;
    end
    if (all_low) begin
      need = lenient ? t_len : t_norm;
      if (!still_seen) begin
        still_seen = 1;
        still_t0 = t;
        deadline = time_sat(t, tmo);
      end else if (t > still_t0 + need) begin
        return 1;
      end
    end else if (any_high && still_seen) begin
      hold_until = time_sat(t, asod_pkg::HoldoffUs);
      still_seen = 0;
    end
    return 0;
  endfunction

  // one input word in, one status word predicted
  function automatic status_t predict_status(logic [1:0] op, longint unsigned t,
                                             longint s_in [asod_pkg::AxisN]);
    status_t r;
    r = '0;
    if (op == asod_pkg::OpStart) begin
      running = 1;
      for (int i = 0; i < asod_pkg::AxisN; i++) begin
        avg[i] = 0;
        disp[i] = 0;
      end
      prev_t = t;
      still_t0 = 0;
      still_seen = 0;
      deadline = time_sat(t, tmo);
      late_cnt = 0;
      hold_until = 0;
    end else if (running && t >= hold_until) begin
      if (op == asod_pkg::OpSample && sample_update(t, s_in)) begin
        r.done = 1;
        r.orient = orient_of();
        running = 0;
      end else begin
        if (prev_t > deadline && late_cnt < 65535) late_cnt++;
        if (late_cnt > err_lim) begin
          r.done = 1;
          running = 0;
        end
      end
    end
    r.active = running;
    return r;
  endfunction

  // observe the ports: compare outputs first, then predict from inputs
  always @(posedge clk_i or negedge rst_ni) begin
    status_t         exp_s;
    longint          s_in [asod_pkg::AxisN];
    if (!rst_ni) begin
      lenient = 0; thr_sq = 65536; t_norm = 1300000; t_len = 500000;
      tmo = 10000000; err_lim = 1000; ema_w = 8590; grav_thr = 5120;
      running = 0; still_seen = 0;
      for (int i = 0; i < asod_pkg::AxisN; i++) begin
        avg[i] = 0;
        disp[i] = 0;
      end
      prev_t = 0; still_t0 = 0; deadline = 0; hold_until = 0; late_cnt = 0;
      status_q.delete();
      fail_cnt_o <= 0;
      results_o <= 0;
      finished_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (status_q.size() == 0) begin
          $display("%0t: unexpected word: done %0d orient %0d active %0d", $time,
                   done_res_i, orientation_i, active_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_s = status_q.pop_front();
          if (exp_s.done) finished_o <= finished_o + 1;
          if (exp_s != {done_res_i, orientation_i, active_i}) begin
            $display("%0t: mismatch: expected done %0d orient %0d active %0d, got %0d %0d %0d",
                     $time, exp_s.done, exp_s.orient, exp_s.active,
                     done_res_i, orientation_i, active_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        s_in[0] = accel_x_i;
        s_in[1] = accel_y_i;
        s_in[2] = accel_z_i;
        status_q.push_back(predict_status(opcode_i, time_us_i, s_in));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          asod_pkg::RegLenient:  lenient  = cfg_data_i[0];
          asod_pkg::RegThr:      thr_sq   = cfg_data_i[23:0];
          asod_pkg::RegTimeNorm: t_norm   = cfg_data_i[23:0];
          asod_pkg::RegTimeLen:  t_len    = cfg_data_i[23:0];
          asod_pkg::RegTimeout:  tmo      = cfg_data_i[27:0];
          asod_pkg::RegErrLim:   err_lim  = cfg_data_i[15:0];
          asod_pkg::RegEmaW:     ema_w    = cfg_data_i[15:0];
          asod_pkg::RegGravThr:  grav_thr = cfg_data_i[14:0];
          default: ;
        endcase
      end
      pending_o <= status_q.size();
    end
  end

endmodule

@@ bench/accel_still_orientation_detector_unit_test.sv @@
// ----------------------------------------------------------------------------
// accel_still_orientation_detector_unit_test: testbench top
// Drives start, sample and tick words through several register settings and
// flow-control phases, including arm-settle-classify sequences for every
// orientation, shakes into holdoff, late counting and raw noise words.
// ----------------------------------------------------------------------------
module accel_still_orientation_detector_unit_test;

  localparam logic [1:0] OpTick  = 2'd2;
  localparam logic [1:0] OpSpare = 2'd3;
  localparam int         StallLimit = 20000;
  localparam int         ItemsWanted = 900;

  typedef struct {
    logic [27:0] val [8];
  } reg_set_t;

  logic               clk, rst_n;
  logic               in_valid, in_stall, out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         opcode;
  logic [39:0]        time_us;
  logic signed [15:0] accel_x, accel_y, accel_z;
  logic               done_res, active;
  logic [2:0]         orientation;
  logic               cfg_we;
  logic [2:0]         cfg_idx;
  logic [27:0]        cfg_data;
  int                 fail_cnt, pending, results, finished;

  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_reqs = 0;
  int                 holds_done = 0;
  int                 hold_left = 0;
  int                 n_items;
  int                 idle_cnt = 0;
  longint unsigned    now_us;
  int unsigned        grav_thr_now;

  accel_still_orientation_detector_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .time_us_i(time_us),
    .accel_x_i(accel_x), .accel_y_i(accel_y), .accel_z_i(accel_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .done_res_o(done_res), .orientation_o(orientation), .active_o(active),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  accel_still_orientation_detector_unit_check u_check (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .time_us_i(time_us),
    .accel_x_i(accel_x), .accel_y_i(accel_y), .accel_z_i(accel_z),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .done_res_i(done_res), .orientation_i(orientation), .active_i(active),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_cnt_o(fail_cnt), .pending_o(pending),
    .results_o(results), .finished_o(finished)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done < hold_reqs) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic send_word(logic [1:0] op, longint unsigned t, int x, int y, int z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    time_us  <= t[39:0];
    accel_x  <= 16'(x);
    accel_y  <= 16'(y);
    accel_z  <= 16'(z);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  // quiet the sender until every result is back, plus the block's latency
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_regs(reg_set_t rs);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= 3'(i);
      cfg_data <= rs.val[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    grav_thr_now = rs.val[asod_pkg::RegGravThr];
  endtask

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  // arm, then settle on one orientation or a random vector with noise, ticks and shakes
  task automatic run_sequence();
    int  side, n, amp, base [3], off;
    side = $urandom_range(6);
    for (int i = 0; i < 3; i++) base[i] = 0;
    if (side < 6) base[side / 2] = (side % 2) ? -10042 : 10042;
    else for (int i = 0; i < 3; i++) base[i] = $urandom_range(24000) - 12000;
    off = (grav_thr_now > 0 && $urandom_range(3) == 0) ? grav_thr_now : 0;
    for (int i = 0; i < 3; i++) base[i] += $urandom_range(2 * off) - off;
    amp = $urandom_range(3) == 0 ? $urandom_range(400) : $urandom_range(8);
    n = $urandom_range(3, 18);
    now_us += $urandom_range(5000);
    send_word(asod_pkg::OpStart, now_us, $urandom, $urandom, $urandom);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0:  now_us += 0;
        1:  now_us -= (now_us > 700) ? 700 : 0;
        2:  now_us += $urandom_range(300000);
        default: now_us += $urandom_range(200, 3000);
      endcase
      if ($urandom_range(9) == 0) begin
        send_word(OpTick, now_us, 0, 0, 0);
      end else if ($urandom_range(11) == 0) begin
        send_word(asod_pkg::OpSample, now_us,
                  clamp16(base[0] + $urandom_range(40000) - 20000),
                  clamp16(base[1] + $urandom_range(40000) - 20000), base[2]);
      end else begin
        send_word(asod_pkg::OpSample, now_us,
                  clamp16(base[0] + $urandom_range(2 * amp) - amp),
                  clamp16(base[1] + $urandom_range(2 * amp) - amp),
                  clamp16(base[2] + $urandom_range(2 * amp) - amp));
      end
    end
  endtask

  reg_set_t sets [5];

  initial begin
    in_valid = 1'b0; opcode = asod_pkg::OpStart; time_us = '0;
    accel_x = '0; accel_y = '0; accel_z = '0;
    cfg_we = 1'b0; cfg_idx = asod_pkg::RegLenient; cfg_data = '0;
    n_items = 0;
    now_us = 1000; grav_thr_now = 5120;
    rst_n = 1'b0;
    // lenient, thr, normal time, lenient time, timeout, error limit, weight, gravity thr
    sets[0].val = '{0, 65536, 3000, 2000, 20000, 5, 65535, 5120};
    sets[1].val = '{1, 24'hFFFFFF, 0, 0, 0, 0, 0, 15'h7FFF};
    sets[2].val = '{1, 4000, 24'hFFFFFF, 1500, 28'hFFFFFFF, 16'hFFFF, 30000, 0};
    sets[3].val = '{0, 0, 500, 400, 100, 3, 200, 1000};
    sets[4].val = '{0, 20000, 2500, 9999, 5000, 40, 65535, 3000};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: defaults first, then quick settling
    send_word(asod_pkg::OpSample, 50, 1, 1, 1);
    send_word(asod_pkg::OpStart, 100, 0, 0, 0);
    send_word(asod_pkg::OpSample, 200, -32768, 32767, -32768);
    send_word(OpTick, 300, 0, 0, 0);
    send_word(OpSpare, 400, 0, 0, 0);
    send_word(asod_pkg::OpSample, 150, 32767, -32768, 32767);
    write_regs(sets[0]);
    for (int k = 0; k < 2; k++) begin
      send_word(asod_pkg::OpStart, 1000, 0, 0, 0);
      for (int j = 0; j < 5; j++) begin
        send_word(asod_pkg::OpSample, 2000 + j * 1500, 0, 0, k ? -10042 : 10042);
      end
    end
    send_word(asod_pkg::OpStart, 64'hFFFFFFFF00, 0, 0, 0);
    send_word(asod_pkg::OpSample, 64'hFFFFFFFFF0, 10042, 0, 0);
    send_word(asod_pkg::OpSample, 64'hFFFFFFFFFF, 10042, 0, 0);
    send_word(OpTick, 64'hFFFFFFFFFF, 0, 0, 0);
    drain();

    // random phases over register settings and flow-control modes
    for (int p = 0; n_items < ItemsWanted; p++) begin
      write_regs(sets[(p * 3 + 1) % 5]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      if (p % 4 == 0) hold_reqs++;
      for (int q = 0; q < 8; q++) begin
        if ($urandom_range(6) == 0) begin
          now_us = {$urandom, $urandom} & 64'hFFFFFFFFFF;
          send_word(2'($urandom), now_us, $urandom, $urandom, $urandom);
        end else begin
          run_sequence();
        end
      end
      drain();
      if (now_us > 64'hF000000000) now_us = 1000;
    end

    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    $display("Sent %0d words, checked %0d results, %0d detections finished,",
             n_items, results, finished);
    $display("over five register settings and four flow-control modes.");
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
